FILE: rtl/rrfg_pkg.sv
// Package for the random RGB fade generator.
// Holds the random generator state type, the episode kind codes and the fixed constants.
// Depends on nothing.
package rrfg_pkg;

  localparam int unsigned NUM_CH = 3;

  localparam logic [15:0] IDLE_TICKS_RESET = 16'd500;
  localparam logic [15:0] RAMP_TICKS = 16'd512;
  localparam logic [15:0] HALF_TICKS = 16'd256;
  localparam logic [7:0] FULL_STEP = 8'hFF;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_RAMP = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] count;
    logic [7:0] mix_a;
    logic [7:0] mix_b;
    logic [7:0] out_c;
  } gen_t;

  localparam gen_t GEN_RESET = '{count: 8'hCA, mix_a: 8'hFE, mix_b: 8'hBA, out_c: 8'hBE};

  // One draw of the XABC generator; the drawn byte is out_c of the result.
  function automatic gen_t draw_byte(input gen_t g);
    gen_t n;
    n.count = g.count + 8'd1;
    n.mix_a = g.mix_a ^ g.out_c ^ n.count;
    n.mix_b = g.mix_b + n.mix_a;
    n.out_c = g.out_c + ((n.mix_b >> 1) ^ n.mix_a);
    return n;
  endfunction

endpackage

FILE: rtl/random_rgb_fade_generator.sv
// Top level of the random RGB fade generator.
// Uses rrfg_pkg for the generator type, the episode kinds and the constants.
//
// Usage: each input beat carries in_advance. A beat with in_advance high moves the
// fade animation by one tick; a beat with in_advance low leaves the state as it is.
// Every accepted input beat gives exactly one output beat with the three PWM duties,
// the channel enables and an episode start flag.
// The result of a beat accepted at one edge is shown on the output ports right after
// that edge. One beat can be accepted in every cycle while in_stall is low; the
// rate is set by the single result register, which is refilled as it is emptied.
// When the receiver holds out_stall high while a result waits, in_stall goes high
// and the result stays unchanged until it is taken.
// Synchronous reset (rst_n low) empties the result register, sets the random
// generator to its seed, clears all sums and steps, ends any episode and sets
// idle_ticks to 500. cfg_wr_en writes idle_ticks and should be used only while
// no beat is in flight.
module random_rgb_fade_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_duty_one,
  output logic [7:0]  out_duty_two,
  output logic [7:0]  out_duty_three,
  output logic [2:0]  out_channel_enables,
  output logic        out_episode_start
);

  logic [15:0]     idle_ticks_r;
  rrfg_pkg::gen_t  gen_r, gen_nxt;
  rrfg_pkg::kind_t kind_r, kind_nxt;
  logic [15:0]     ticks_left_r, ticks_left_nxt;
  logic [7:0]      steps_r [rrfg_pkg::NUM_CH];
  logic [7:0]      steps_nxt [rrfg_pkg::NUM_CH];
  logic [15:0]     sums_r [rrfg_pkg::NUM_CH];
  logic [15:0]     sums_nxt [rrfg_pkg::NUM_CH];
  logic            start_nxt;
  logic [2:0]      enables_nxt;

  rrfg_pkg::gen_t  gen_one, gen_two, gen_three;
  logic [1:0]      draw_pick;
  logic [1:0]      full_idx, other_idx;
  logic            ramp_up;
  logic            in_fire;

  logic            out_valid_r;
  logic [7:0]      duty_one_r, duty_two_r, duty_three_r;
  logic [2:0]      enables_r;
  logic            start_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign gen_one   = rrfg_pkg::draw_byte(gen_r);
  assign gen_two   = rrfg_pkg::draw_byte(gen_one);
  assign gen_three = rrfg_pkg::draw_byte(gen_two);
  assign draw_pick = gen_one.out_c[1:0];
  assign ramp_up   = ticks_left_r > rrfg_pkg::HALF_TICKS;

  always_comb begin
    full_idx  = 2'd0;
    other_idx = 2'd1;
    unique case (draw_pick)
      2'd1: begin
        full_idx  = 2'd0;
        other_idx = gen_two.out_c[0] ? 2'd1 : 2'd2;
      end
      2'd2: begin
        full_idx  = 2'd1;
        other_idx = gen_two.out_c[0] ? 2'd0 : 2'd2;
      end
      2'd3: begin
        full_idx  = 2'd2;
        other_idx = gen_two.out_c[0] ? 2'd0 : 2'd1;
      end
      default: begin
        full_idx  = 2'd0;
        other_idx = 2'd1;
      end
    endcase
  end

  always_comb begin
    gen_nxt        = gen_r;
    kind_nxt       = kind_r;
    ticks_left_nxt = ticks_left_r;
    steps_nxt      = steps_r;
    sums_nxt       = sums_r;
    start_nxt      = 1'b0;
    if (in_advance) begin
      if (kind_r == rrfg_pkg::KIND_NONE) begin
        start_nxt = 1'b1;
        for (int k = 0; k < rrfg_pkg::NUM_CH; k++) begin
          steps_nxt[k] = 8'd0;
          sums_nxt[k]  = 16'd0;
        end
        if (draw_pick == 2'd0) begin
          gen_nxt = gen_one;
          if (idle_ticks_r <= 16'd1) begin
            kind_nxt       = rrfg_pkg::KIND_NONE;
            ticks_left_nxt = 16'd0;
          end else begin
            kind_nxt       = rrfg_pkg::KIND_IDLE;
            ticks_left_nxt = idle_ticks_r - 16'd1;
          end
        end else begin
          gen_nxt = gen_three;
          steps_nxt[full_idx]  = rrfg_pkg::FULL_STEP;
          steps_nxt[other_idx] = gen_three.out_c;
          for (int k = 0; k < rrfg_pkg::NUM_CH; k++) begin
            sums_nxt[k] = {8'd0, steps_nxt[k]};
          end
          kind_nxt       = rrfg_pkg::KIND_RAMP;
          ticks_left_nxt = rrfg_pkg::RAMP_TICKS - 16'd1;
        end
      end else begin
        if (kind_r != rrfg_pkg::KIND_IDLE) begin
          for (int k = 0; k < rrfg_pkg::NUM_CH; k++) begin
            if (ramp_up) begin
              sums_nxt[k] = sums_r[k] + {8'd0, steps_r[k]};
            end else begin
              sums_nxt[k] = sums_r[k] - {8'd0, steps_r[k]};
            end
          end
        end
        if (ticks_left_r != 16'd0) begin
          ticks_left_nxt = ticks_left_r - 16'd1;
        end
        if (ticks_left_nxt == 16'd0) begin
          kind_nxt = rrfg_pkg::KIND_NONE;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < rrfg_pkg::NUM_CH; k++) begin
      enables_nxt[k] = steps_nxt[k] != 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= rrfg_pkg::IDLE_TICKS_RESET;
    end else if (cfg_wr_en) begin
      idle_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r        <= rrfg_pkg::GEN_RESET;
      kind_r       <= rrfg_pkg::KIND_NONE;
      ticks_left_r <= 16'd0;
      for (int k = 0; k < rrfg_pkg::NUM_CH; k++) begin
        steps_r[k] <= 8'd0;
        sums_r[k]  <= 16'd0;
      end
    end else if (in_fire) begin
      gen_r        <= gen_nxt;
      kind_r       <= kind_nxt;
      ticks_left_r <= ticks_left_nxt;
      steps_r      <= steps_nxt;
      sums_r       <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      duty_one_r   <= sums_nxt[0][15:8];
      duty_two_r   <= sums_nxt[1][15:8];
      duty_three_r <= sums_nxt[2][15:8];
      enables_r    <= enables_nxt;
      start_r      <= start_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_duty_one        = duty_one_r;
  assign out_duty_two        = duty_two_r;
  assign out_duty_three      = duty_three_r;
  assign out_channel_enables = enables_r;
  assign out_episode_start   = start_r;

`ifndef ASSERT_OFF
  // An episode is running exactly when ticks remain in it.
  a_kind_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == rrfg_pkg::KIND_NONE) == (ticks_left_r == 16'd0))
    else $error("episode kind and remaining ticks disagree");

  // A running ramp always has one channel at full step.
  a_ramp_full: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == rrfg_pkg::KIND_RAMP) |->
      (steps_r[0] == rrfg_pkg::FULL_STEP) || (steps_r[1] == rrfg_pkg::FULL_STEP) ||
      (steps_r[2] == rrfg_pkg::FULL_STEP))
    else $error("ramp running without a full-step channel");

  // Every accepted beat leaves a result waiting in the next cycle.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

  // A fresh episode shows either an enabled channel or all duties at zero.
  a_start_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && start_r) |->
      (enables_r != 3'd0) ||
      ((duty_one_r == 8'd0) && (duty_two_r == 8'd0) && (duty_three_r == 8'd0)))
    else $error("episode start with inconsistent outputs");
`endif

endmodule
